>>> rtl/stm_pkg.sv
// shared types, preset tables and sine builder for the stereo tremolo modulator
package stm_pkg;

    localparam int unsigned TABLE_PRESETS = 8;
    localparam int unsigned SEL_W         = 3;
    localparam int unsigned DEPTH_W       = 16;
    localparam int unsigned CARRIER_W     = 17;
    localparam int unsigned SETTING_W     = 16;
    localparam int unsigned PHASE_W       = 32;

    // unity carrier in q1.16
    localparam logic [CARRIER_W-1:0] CARRIER_ONE = 17'h10000;

    typedef logic [SEL_W-1:0]     t_sel;
    typedef logic [DEPTH_W-1:0]   t_depth;
    typedef logic [CARRIER_W-1:0] t_carrier;
    typedef logic [PHASE_W-1:0]   t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROM,
        ST_CARR,
        ST_MULT
    } t_state;

    // control from the sequencer to the carrier unit
    typedef struct packed {
        logic load;
        logic restart;
        t_sel sel;
    } t_phase_ctl;

    localparam t_depth PRESET_DEPTH [TABLE_PRESETS] = '{
        16'd6554,  16'd13107, 16'd19661, 16'd26214,
        16'd32768, 16'd39322, 16'd45875, 16'd52429
    };

    // round(fc / 44100 * 2^32) for each preset
    localparam t_phase PRESET_STEP [TABLE_PRESETS] = '{
        32'd2921746,  32'd4869577,  32'd7791324,  32'd8765239,
        32'd9739155,  32'd19478310, 32'd29217465, 32'd38956619
    };

    // taylor coefficients of sin(pi/2 * x), q30 magnitudes
    localparam logic [63:0] COEF1 = 64'd1686629713;
    localparam logic [63:0] COEF3 = 64'd693598668;
    localparam logic [63:0] COEF5 = 64'd85569273;
    localparam logic [63:0] COEF7 = 64'd5026993;
    localparam logic [63:0] COEF9 = 64'd172273;

    // quarter-wave entry k of a table with 2^(table_bits-2) steps, q1.16
    function automatic t_carrier quarter_sine(input int unsigned k,
                                              input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        x  = 64'(k) << (30 - (table_bits - 2));
        x2 = (x * x) >> 30;
        p  = COEF7 - ((x2 * COEF9) >> 30);
        p  = COEF5 - ((x2 * p) >> 30);
        p  = COEF3 - ((x2 * p) >> 30);
        p  = COEF1 - ((x2 * p) >> 30);
        p  = (x * p) >> 30;
        p  = (p + 64'd8192) >> 14;
        if (p > 64'd65536) begin
            p = 64'd65536;
        end
        return CARRIER_W'(p);
    endfunction

endpackage

>>> rtl/stm_carrier.sv
// phase accumulator, quarter-wave sine rom and carrier gain for the tremolo
module stm_carrier #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stm_pkg::t_phase_ctl   i_ctl,
    output stm_pkg::t_carrier     o_carrier
);

    localparam int unsigned OFF_W = SINE_TABLE_BITS - 2;
    localparam int unsigned ADR_W = SINE_TABLE_BITS - 1;
    localparam int unsigned QLEN  = 1 << OFF_W;

    typedef stm_pkg::t_carrier t_rom [QLEN + 1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int unsigned k = 0; k <= QLEN; k++) begin
            rom[k] = stm_pkg::quarter_sine(k, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom QROM = build_rom();

    stm_pkg::t_phase   r_phase;
    logic [ADR_W-1:0]  r_addr;
    logic              r_neg;
    stm_pkg::t_sel     r_sel;
    stm_pkg::t_carrier r_rom;
    stm_pkg::t_carrier r_carrier;

    stm_pkg::t_phase   phase_used;
    logic [1:0]        quad;
    logic [OFF_W-1:0]  off;
    logic [ADR_W-1:0]  addr;
    logic [33:0]       gain_sum;
    stm_pkg::t_carrier m;

    assign phase_used = i_ctl.restart ? '0 : r_phase;
    assign quad       = phase_used[stm_pkg::PHASE_W-1 -: 2];
    assign off        = phase_used[stm_pkg::PHASE_W-3 -: OFF_W];
    // odd quadrants walk the quarter table backwards
    assign addr       = quad[0] ? ADR_W'(QLEN) - ADR_W'(off) : ADR_W'(off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.load) begin
            r_phase <= phase_used + stm_pkg::PRESET_STEP[i_ctl.sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr <= addr;
            r_neg  <= quad[1];
            r_sel  <= i_ctl.sel;
        end
    end

    // registered rom read
    always_ff @(posedge i_clk) begin
        r_rom <= QROM[r_addr];
    end

    assign gain_sum = 34'(stm_pkg::PRESET_DEPTH[r_sel] * r_rom) + 34'd32768;
    assign m        = gain_sum[32:16];

    always_ff @(posedge i_clk) begin
        r_carrier <= r_neg ? stm_pkg::CARRIER_ONE - m : stm_pkg::CARRIER_ONE + m;
    end

    assign o_carrier = r_carrier;

    a_restart_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load && i_ctl.restart) |=> r_phase == stm_pkg::PRESET_STEP[$past(i_ctl.sel)])
        else $error("phase after restart is not one step");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.load |=> $stable(r_phase))
        else $error("phase moved without a transaction");

endmodule

>>> rtl/stm_lane.sv
// one channel lane: scale a sample by the carrier, round and saturate
module stm_lane #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  stm_pkg::t_carrier             i_carrier,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int unsigned PROD_W = SAMPLE_BITS + stm_pkg::CARRIER_W;

    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS:0]   scaled;
    logic [SAMPLE_BITS:0]   pos_lim;
    logic [SAMPLE_BITS:0]   neg_lim;
    logic [SAMPLE_BITS:0]   clamped;

    assign pos_lim = (SAMPLE_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
    assign neg_lim = (SAMPLE_BITS + 1)'(1 << (SAMPLE_BITS - 1));

    // magnitude of the most negative code wraps to 2^(n-1), which is exact
    assign mag    = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : i_sample;
    assign prod   = PROD_W'(mag * i_carrier) + PROD_W'(32768);
    assign scaled = prod[PROD_W-1:16];

    always_comb begin
        if (i_sample[SAMPLE_BITS-1]) begin
            clamped  = (scaled > neg_lim) ? neg_lim : scaled;
            o_result = SAMPLE_BITS'(-clamped);
        end else begin
            clamped  = (scaled > pos_lim) ? pos_lim : scaled;
            o_result = SAMPLE_BITS'(clamped);
        end
    end

endmodule

>>> rtl/stereo_tremolo_modulator.sv
// stereo tremolo top level: sequencer, two sample lanes and output register
//
//  channel   direction  signals                            payload
//  s (in)    slave      i_s_tvalid o_s_tready i_s_tdata    left, right samples
//                       i_s_tuser                          block_start
//  m (out)   master     o_m_tvalid i_m_tready o_m_tdata    left_out, right_out
//  cfg       slave      i_cfg_valid o_cfg_ready i_cfg_data effect_setting
//
// each stereo pair passes through the sequencer in order: accept and phase step,
// sine rom read, carrier gain multiply, lane multiply into the output register
// one pair is in flight at a time; the next pair is taken as soon as the
// current one reaches the output register, even if that result still waits
// a stalled output register holds the sequencer in its last stage
// synchronous active-low reset clears phase, setting and all valid state
module stereo_tremolo_modulator #(
    parameter int unsigned SAMPLE_BITS     = 16,
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned PRESET_COUNT    = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream transaction
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // [0] block_start
    input  logic                                   i_s_tuser,
    // output stream transaction
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     o_m_tdata,
    // setting write transaction
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [stm_pkg::SETTING_W-1:0]          i_cfg_data
);

    localparam int unsigned DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    stm_pkg::t_state                r_state;
    stm_pkg::t_state                n_state;
    logic [stm_pkg::SETTING_W-1:0]  r_setting;
    logic signed [SAMPLE_BITS-1:0]  r_left;
    logic signed [SAMPLE_BITS-1:0]  r_right;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_left_out;
    logic signed [SAMPLE_BITS-1:0]  r_right_out;

    logic                           in_accept;
    logic                           out_load;
    stm_pkg::t_sel                  sel;
    stm_pkg::t_phase_ctl            phase_ctl;
    stm_pkg::t_carrier              carrier;
    logic signed [SAMPLE_BITS-1:0]  left_mod;
    logic signed [SAMPLE_BITS-1:0]  right_mod;

    // setting register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_setting <= i_cfg_data;
        end
    end

    // settings past the preset table fall back to preset 0
    assign sel = (r_setting < stm_pkg::SETTING_W'(PRESET_COUNT) &&
                  r_setting < stm_pkg::SETTING_W'(stm_pkg::TABLE_PRESETS))
               ? r_setting[stm_pkg::SEL_W-1:0] : '0;

    assign in_accept = i_s_tvalid && o_s_tready;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stm_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = stm_pkg::ST_ROM;
                end
            end
            stm_pkg::ST_ROM:  n_state = stm_pkg::ST_CARR;
            stm_pkg::ST_CARR: n_state = stm_pkg::ST_MULT;
            stm_pkg::ST_MULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = stm_pkg::ST_IDLE;
                end
            end
            default: n_state = stm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            stm_pkg::ST_IDLE: o_s_tready = 1'b1;
            stm_pkg::ST_ROM:  ;
            stm_pkg::ST_CARR: ;
            stm_pkg::ST_MULT: out_load = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the pair while the carrier is worked out
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_left  <= i_s_tdata[SAMPLE_BITS-1:0];
            r_right <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    assign phase_ctl.load    = in_accept;
    assign phase_ctl.restart = i_s_tuser;
    assign phase_ctl.sel     = sel;

    stm_carrier #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_carrier (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (phase_ctl),
        .o_carrier (carrier)
    );

    // both channels share one carrier, one lane each
    stm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_sample  (r_left),
        .i_carrier (carrier),
        .o_result  (left_mod)
    );

    stm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_sample  (r_right),
        .i_carrier (carrier),
        .o_result  (right_mod)
    );

    // merge stage: both lane results land in one output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left_out  <= left_mod;
            r_right_out <= right_mod;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_W'({r_right_out, r_left_out});

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == stm_pkg::ST_ROM)
        else $error("accepted pair did not start the sequence");

    a_load_from_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == stm_pkg::ST_MULT)
        else $error("result appeared outside the last stage");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != stm_pkg::ST_IDLE) |-> !o_s_tready)
        else $error("input taken while a pair is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_left_out) && $stable(r_right_out))
        else $error("waiting result was overwritten");

endmodule

>>> sim/tb_stereo_tremolo_modulator.sv
// self-checking testbench for the stereo tremolo modulator
module tb_stereo_tremolo_modulator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLE_BITS     = 16;
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned PRESET_COUNT    = 8;
    localparam int unsigned DATA_W          = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned QUARTER_STEPS   = 1 << (SINE_TABLE_BITS - 2);
    localparam int unsigned RANDOM_PAIRS    = 1450;
    // cycles a pair may still spend inside the block after its result arrived
    localparam int unsigned SETTLE_CYCLES   = 8;
    // cycles without any transaction before the run is declared hung
    localparam int unsigned HANG_LIMIT      = 600;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample left;
        t_sample right;
    } t_stereo;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;
    logic              i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [stm_pkg::SETTING_W-1:0] i_cfg_data;

    // model state: carrier phase, preset setting and the sine quarter wave
    logic [stm_pkg::PHASE_W-1:0]   carrier_phase;
    logic [stm_pkg::SETTING_W-1:0] effect_setting;
    stm_pkg::t_carrier             quarter_wave [0:QUARTER_STEPS];

    // modulated pairs still on their way out of the block
    t_stereo modulated_pairs [$];

    int unsigned mismatch_count;
    int unsigned pairs_sent;
    int unsigned rx_stall_left;
    // calm flags switch off random gaps on one side for a whole stretch
    bit          tx_calm;
    bit          rx_calm;

    stereo_tremolo_modulator #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PRESET_COUNT    (PRESET_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // odd taylor series of sin(pi/2 * x) in q30, horner form from the x^9 term down,
    // rounded half up to q1.16 and clamped to unity
    function automatic stm_pkg::t_carrier sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] coef [4];
        coef = '{stm_pkg::COEF7, stm_pkg::COEF5, stm_pkg::COEF3, stm_pkg::COEF1};
        x    = 64'(k) << (30 - (SINE_TABLE_BITS - 2));
        x2   = (x * x) >> 30;
        acc  = stm_pkg::COEF9;
        for (int i = 0; i < 4; i++) begin
            acc = coef[i] - ((x2 * acc) >> 30);
        end
        acc = (x * acc) >> 30;
        acc = (acc + 64'd8192) >> 14;
        if (acc > 64'd65536) begin
            acc = 64'd65536;
        end
        return stm_pkg::t_carrier'(acc);
    endfunction

    // sample times q1.16 gain, rounded half away from zero, saturated
    function automatic t_sample scale_sample(input t_sample s,
                                             input stm_pkg::t_carrier gain);
        int          v;
        logic [63:0] mag;
        v   = s;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag * 64'(gain) + 64'd32768) >> 16;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        if (v < 0) begin
            return t_sample'(-mag);
        end
        if (mag > 64'd32767) begin
            return t_sample'(16'sd32767);
        end
        return t_sample'(mag);
    endfunction

    // one pair through the tremolo, advancing the carrier phase
    function automatic t_stereo modulate_pair(input t_sample left, input t_sample right,
                                              input logic restart);
        stm_pkg::t_sel              sel;
        logic [SINE_TABLE_BITS-1:0] addr;
        logic [1:0]                 quadrant;
        logic [SINE_TABLE_BITS-3:0] offset;
        stm_pkg::t_carrier          level;
        logic [63:0]                swing;
        stm_pkg::t_carrier          gain;
        t_stereo                    res;
        // settings past the preset table fall back to the first preset
        sel = (effect_setting < PRESET_COUNT && effect_setting < stm_pkg::TABLE_PRESETS)
              ? stm_pkg::t_sel'(effect_setting) : '0;
        if (restart) begin
            carrier_phase = '0;
        end
        addr     = carrier_phase[stm_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
        quadrant = addr[SINE_TABLE_BITS-1 -: 2];
        offset   = addr[SINE_TABLE_BITS-3:0];
        // odd quadrants run the quarter wave backwards
        level    = quadrant[0] ? quarter_wave[QUARTER_STEPS - offset] : quarter_wave[offset];
        swing    = (64'(stm_pkg::PRESET_DEPTH[sel]) * 64'(level) + 64'd32768) >> 16;
        // second half of the wave lowers the gain below unity
        gain     = quadrant[1] ? stm_pkg::CARRIER_ONE - stm_pkg::t_carrier'(swing)
                               : stm_pkg::CARRIER_ONE + stm_pkg::t_carrier'(swing);
        res.left  = scale_sample(left, gain);
        res.right = scale_sample(right, gain);
        carrier_phase = carrier_phase + stm_pkg::PRESET_STEP[sel];
        return res;
    endfunction

    // extremes show up often so that saturation and rounding edges get hit
    function automatic t_sample pick_sample();
        unique case ($urandom_range(0, 9))
            0:       return t_sample'(16'h8000);
            1:       return t_sample'(16'h7fff);
            2:       return t_sample'(16'hffff);
            3:       return t_sample'(16'h0000);
            4:       return t_sample'(16'h0001);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [stm_pkg::SETTING_W-1:0] pick_setting(
        input int unsigned stretch);
        // first stretches walk every preset in order
        if (stretch < stm_pkg::TABLE_PRESETS) begin
            return stm_pkg::SETTING_W'(stretch);
        end
        unique case ($urandom_range(0, 5))
            0:       return '1;
            1:       return stm_pkg::SETTING_W'(stm_pkg::TABLE_PRESETS);
            2:       return stm_pkg::SETTING_W'($urandom_range(stm_pkg::TABLE_PRESETS,
                                                               65535));
            default: return stm_pkg::SETTING_W'($urandom_range(0,
                                                               stm_pkg::TABLE_PRESETS - 1));
        endcase
    endfunction

    // send one stereo pair, leaving tvalid high in case the next one follows at once
    task automatic send_pair(input t_sample left, input t_sample right,
                             input logic restart);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {right, left};
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        modulated_pairs.push_back(modulate_pair(left, right, restart));
        pairs_sent++;
    endtask

    // stop sending and wait until every pair has come out and the block settled
    task automatic drain_pairs();
        i_s_tvalid <= 1'b0;
        while (modulated_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [stm_pkg::SETTING_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        effect_setting  = value;
    endtask

    // setting and phase straight out of reset, no restart flag given
    task automatic test_reset_state();
        send_pair(t_sample'(16'h7fff), t_sample'(16'h8000), 1'b0);
        send_pair(t_sample'(16'h8000), t_sample'(16'h7fff), 1'b0);
        send_pair(t_sample'(16'h0000), t_sample'(16'hffff), 1'b0);
        send_pair(t_sample'(16'h0001), t_sample'(16'h0000), 1'b0);
        drain_pairs();
    endtask

    // deepest preset drives the gain well above unity so both rails saturate
    task automatic test_saturation();
        t_sample rails [4];
        rails = '{t_sample'(16'h7fff), t_sample'(16'h8000),
                  t_sample'(16'h0001), t_sample'(16'hffff)};
        write_setting(stm_pkg::SETTING_W'(stm_pkg::TABLE_PRESETS - 1));
        send_pair(t_sample'(16'h7fff), t_sample'(16'h8000), 1'b1);
        for (int i = 0; i < 12; i++) begin
            send_pair(rails[i % 4], rails[(i + 1) % 4], 1'b0);
        end
        drain_pairs();
    endtask

    // settings beyond the table fall back to the first preset; phase carries on, with one restart in the second group
    task automatic test_setting_overflow();
        write_setting('1);
        for (int i = 0; i < 3; i++) begin
            send_pair(pick_sample(), pick_sample(), 1'b0);
        end
        drain_pairs();
        write_setting(stm_pkg::SETTING_W'(stm_pkg::TABLE_PRESETS));
        for (int i = 0; i < 3; i++) begin
            send_pair(pick_sample(), pick_sample(), i == 1);
        end
        drain_pairs();
    endtask

    // stretches of random pairs, each under its own setting; the phase runs on
    // across setting changes unless a block restart comes
    task automatic test_random_blocks();
        int unsigned stretch;
        int unsigned count;
        int unsigned target;
        logic        restart;
        stretch = 0;
        target  = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < target) begin
            write_setting(pick_setting(stretch));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(30, 110);
            for (int i = 0; i < count; i++) begin
                restart = (i == 0 && $urandom_range(0, 2) == 0) ||
                          ($urandom_range(0, 149) == 0);
                send_pair(pick_sample(), pick_sample(), restart);
            end
            // sender holds off until the block has emptied before the next write
            drain_pairs();
            stretch++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // receiver: a random stall after each output transaction
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            rx_stall_left = rx_calm ? 0 : $urandom_range(0, 18);
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
        end
        i_m_tready <= (rx_stall_left == 0);
    end

    // compare each output transaction with the oldest modulated pair
    always @(posedge i_clk) begin
        t_stereo want;
        t_sample got_left;
        t_sample got_right;
        if (o_m_tvalid && i_m_tready) begin
            got_left  = o_m_tdata[SAMPLE_BITS-1:0];
            got_right = o_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            if (modulated_pairs.size() == 0) begin
                mismatch_count++;
                $error("output transaction with no pair pending: left %0d right %0d",
                       got_left, got_right);
            end else begin
                want = modulated_pairs.pop_front();
                if (got_left !== want.left) begin
                    mismatch_count++;
                    $error("left_out: expected %0d, actual %0d", want.left, got_left);
                end
                if (got_right !== want.right) begin
                    mismatch_count++;
                    $error("right_out: expected %0d, actual %0d", want.right, got_right);
                end
            end
        end
    end

    // hang detector: any transaction on any channel counts as progress
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = 1'b0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        carrier_phase  = '0;
        effect_setting = '0;
        mismatch_count = 0;
        pairs_sent     = 0;
        rx_stall_left  = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            quarter_wave[k] = sine_entry(k);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_saturation();
        test_setting_overflow();
        test_random_blocks();
        drain_pairs();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
